>>> sv/ffha_pkg.sv
package ffha_pkg;

    localparam int MAX_BLOCKS_DEF = 64;
    localparam int ADDR_W         = 32;
    localparam int HDR_W          = 7;
    localparam int NEED_W         = ADDR_W + 2;
    localparam int CFG_IDX_W      = 2;
    localparam int STATUS_W       = 3;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 3'd0,
        ST_IGNORED     = 3'd1,
        ST_HEAP_FULL   = 3'd2,
        ST_TABLE_FULL  = 3'd3,
        ST_UNKNOWN     = 3'd4,
        ST_DOUBLE_FREE = 3'd5
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HEAP_BASE  = 2'd0,
        CFG_HEAP_LIMIT = 2'd1,
        CFG_HEADER     = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic start;
        logic scan;
        logic hit_commit;
        logic miss_commit;
        logic trivial_commit;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic trivial;
        logic hit;
        logic scan_end;
        logic out_free;
    } t_stat;

endpackage

>>> sv/ffha_ctrl.sv
module ffha_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  ffha_pkg::t_stat i_stat,
    output ffha_pkg::t_cmd  o_cmd
);
    import ffha_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_MISS = 4'b0100,
        S_FIN  = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.trivial) begin
                    o_cmd.trivial_commit = 1'b1;
                    n_state              = S_FIN;
                end else if (i_stat.hit) begin
                    o_cmd.hit_commit = 1'b1;
                    n_state          = S_FIN;
                end else if (i_stat.scan_end) begin
                    n_state = S_MISS;
                end
            end
            S_MISS: begin
                o_cmd.miss_commit = 1'b1;
                n_state           = S_FIN;
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_ready = (r_state == S_IDLE);

endmodule

>>> sv/ffha_datapath.sv
module ffha_datapath #(
    parameter int MAX_BLOCKS = ffha_pkg::MAX_BLOCKS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  ffha_pkg::t_cmd                   i_cmd,
    output ffha_pkg::t_stat                  o_stat,
    input  logic                             i_operation,
    input  logic [ffha_pkg::ADDR_W-1:0]      i_req_size,
    input  logic [ffha_pkg::ADDR_W-1:0]      i_address,
    input  logic                             i_cfg_valid,
    input  logic [ffha_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [ffha_pkg::ADDR_W-1:0]      i_cfg_data,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [ffha_pkg::ADDR_W-1:0]      o_result_address,
    output logic [ffha_pkg::STATUS_W-1:0]    o_status
);
    import ffha_pkg::*;

    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam int IW = $clog2(MAX_BLOCKS);

    logic [ADDR_W-1:0] r_heap_base;
    logic [ADDR_W-1:0] r_heap_limit;
    logic [HDR_W-1:0]  r_header;
    logic [CW-1:0]     r_count;
    logic [ADDR_W-1:0] r_used;

    logic [ADDR_W-1:0] mem_base [MAX_BLOCKS];
    logic [ADDR_W-1:0] mem_size [MAX_BLOCKS];
    logic [MAX_BLOCKS-1:0] r_free;

    logic              r_op;
    logic [ADDR_W-1:0] r_size;
    logic [ADDR_W-1:0] r_addr;
    logic [ADDR_W-1:0] r_app_base;
    logic [NEED_W-1:0] r_need;

    logic [CW-1:0]     r_scan_idx;
    logic              r_rd_vld;
    logic [IW-1:0]     r_rd_idx;
    logic [ADDR_W-1:0] r_rd_base;
    logic [ADDR_W-1:0] r_rd_size;
    logic              r_rd_free;

    logic [ADDR_W-1:0] r_res_addr;
    t_status           r_res_status;
    logic              r_out_vld;
    logic [ADDR_W-1:0] r_out_addr;
    t_status           r_out_status;

    logic [ADDR_W-1:0] hdr_ext;
    logic [ADDR_W-1:0] rd_pay;
    logic [ADDR_W-1:0] app_pay;
    logic              match;
    logic              issue;
    logic              table_full;
    logic              heap_full;
    logic              append;

    assign hdr_ext    = {{(ADDR_W-HDR_W){1'b0}}, r_header};
    assign rd_pay     = r_rd_base + hdr_ext;
    assign app_pay    = r_app_base + hdr_ext;
    assign match      = (r_op == OP_ALLOC) ? (r_rd_free && (r_rd_size >= r_size))
                                           : (rd_pay == r_addr);
    assign issue      = (r_scan_idx < r_count);
    assign table_full = (r_count == CW'(MAX_BLOCKS));
    assign heap_full  = (r_need > {2'b00, r_heap_limit});
    assign append     = (r_op == OP_ALLOC) && !table_full && !heap_full;

    assign o_stat.trivial  = (r_op == OP_ALLOC) ? (r_size == '0) : (r_addr == '0);
    assign o_stat.hit      = r_rd_vld && match;
    assign o_stat.scan_end = !r_rd_vld && !issue;
    assign o_stat.out_free = !r_out_vld || i_ready;

    // control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap_base  <= '0;
            r_heap_limit <= 32'd65536;
            r_header     <= 7'd24;
            r_count      <= '0;
            r_used       <= '0;
            r_free       <= '0;
            r_scan_idx   <= '0;
            r_rd_vld     <= 1'b0;
            r_out_vld    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_HEAP_BASE:  r_heap_base  <= i_cfg_data;
                    CFG_HEAP_LIMIT: r_heap_limit <= i_cfg_data;
                    CFG_HEADER:     r_header     <= i_cfg_data[HDR_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.start) begin
                r_scan_idx <= '0;
                r_rd_vld   <= 1'b0;
            end else if (i_cmd.scan) begin
                r_rd_vld <= issue;
                if (issue) begin
                    r_scan_idx <= r_scan_idx + 1'b1;
                end
            end
            if (i_cmd.hit_commit) begin
                r_free[r_rd_idx] <= (r_op == OP_FREE);
            end
            if (i_cmd.miss_commit && append) begin
                r_free[r_count[IW-1:0]] <= 1'b0;
                r_count                 <= r_count + 1'b1;
                r_used                  <= r_need[ADDR_W-1:0];
            end
            if (i_cmd.out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // table memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.miss_commit && append) begin
            mem_base[r_count[IW-1:0]] <= r_app_base;
            mem_size[r_count[IW-1:0]] <= r_size;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_op       <= i_operation;
            r_size     <= i_req_size;
            r_addr     <= i_address;
            r_need     <= {2'b00, r_used} + {{(NEED_W-HDR_W){1'b0}}, r_header}
                          + {2'b00, i_req_size};
            r_app_base <= r_heap_base + r_used;
        end
        if (i_cmd.scan) begin
            r_rd_base <= mem_base[r_scan_idx[IW-1:0]];
            r_rd_size <= mem_size[r_scan_idx[IW-1:0]];
            r_rd_free <= r_free[r_scan_idx[IW-1:0]];
            r_rd_idx  <= r_scan_idx[IW-1:0];
        end
        if (i_cmd.trivial_commit) begin
            r_res_addr   <= '0;
            r_res_status <= ST_IGNORED;
        end else if (i_cmd.hit_commit) begin
            if (r_op == OP_ALLOC) begin
                r_res_addr   <= rd_pay;
                r_res_status <= ST_OK;
            end else begin
                r_res_addr   <= '0;
                r_res_status <= r_rd_free ? ST_DOUBLE_FREE : ST_OK;
            end
        end else if (i_cmd.miss_commit) begin
            if (r_op == OP_FREE) begin
                r_res_addr   <= '0;
                r_res_status <= ST_UNKNOWN;
            end else if (table_full) begin
                r_res_addr   <= '0;
                r_res_status <= ST_TABLE_FULL;
            end else if (heap_full) begin
                r_res_addr   <= '0;
                r_res_status <= ST_HEAP_FULL;
            end else begin
                r_res_addr   <= app_pay;
                r_res_status <= ST_OK;
            end
        end
        if (i_cmd.out_load) begin
            r_out_addr   <= r_res_addr;
            r_out_status <= r_res_status;
        end
    end

    assign o_valid          = r_out_vld;
    assign o_result_address = r_out_addr;
    assign o_status         = r_out_status;

endmodule

>>> sv/first_fit_heap_allocator.sv
// First-fit heap allocator, no split and no coalesce.
//
// Request channel (i_valid / o_ready): one item per request, i_operation
// selects allocate (req_size) or free (address). Result channel (o_valid /
// i_ready): exactly one item per request, a payload address and a status.
// Configuration channel (i_cfg_valid / o_cfg_ready, always ready): index 0
// heap base, 1 heap limit in bytes, 2 header bytes; other indexes are dropped.
//
// The block walks its block table one entry per cycle through the
// registered read port of the table memory and stops at the first hit; a
// miss walks every entry. A zero size or a null address ends the walk at
// once. One request is in flight at a time; o_ready returns when the
// result has been moved to the output register.
//
// Reset clears the table count, the used byte count and every free mark, and
// loads the default configuration. The stored bases and sizes need no clearing
// since only entries below the count are read. When the receiver stalls, the
// output register holds its item and a finished result waits for it.
module first_fit_heap_allocator #(
    parameter int MAX_BLOCKS = ffha_pkg::MAX_BLOCKS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic                             i_operation,
    input  logic [ffha_pkg::ADDR_W-1:0]      i_req_size,
    input  logic [ffha_pkg::ADDR_W-1:0]      i_address,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [ffha_pkg::ADDR_W-1:0]      o_result_address,
    output logic [ffha_pkg::STATUS_W-1:0]    o_status,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [ffha_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [ffha_pkg::ADDR_W-1:0]      i_cfg_data
);
    import ffha_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // the user must write registers only while idle; the block does not enforce it, so take writes at once
    assign o_cfg_ready = 1'b1;

    // sequence the scan, commit and output hand-off
    ffha_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // hold the block table, config, compare logic and output register
    ffha_datapath #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_operation      (i_operation),
        .i_req_size       (i_req_size),
        .i_address        (i_address),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_result_address (o_result_address),
        .o_status         (o_status)
    );

endmodule

>>> sv/ffha_checker.sv
module ffha_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_valid,
    input logic                             o_ready,
    input logic                             o_valid,
    input logic                             i_ready,
    input logic [ffha_pkg::ADDR_W-1:0]      o_result_address,
    input logic [ffha_pkg::STATUS_W-1:0]    o_status
);
    import ffha_pkg::*;

    // a stalled result item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_result_address) && $stable(o_status))
        else $error("result item changed while stalled");

    // failed or ignored requests grant no address
    a_zero_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != ST_OK) |-> (o_result_address == '0))
        else $error("nonzero address on a failed request");

    // one request in flight: busy right after acceptance
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("request taken while another is in flight");

    // no result item out of reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (.*);

>>> test/first_fit_heap_allocator_tb.sv
module first_fit_heap_allocator_tb;
    import ffha_pkg::*;

    localparam int MAX_BLOCKS = MAX_BLOCKS_DEF;
    localparam int DIR_ROWS   = 24;
    // Index 3 maps to no register; the block must drop such a write.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    // One result item: granted payload address and status.
    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        t_status           status;
    } t_grant;

    // One row of the directed table. Where typed is set, the expected item
    // is taken from the row; otherwise it comes from the predictor.
    typedef struct packed {
        logic              op;
        logic [ADDR_W-1:0] size;
        logic [ADDR_W-1:0] addr;
        logic              typed;
        logic [ADDR_W-1:0] exp_addr;
        t_status           exp_status;
    } t_dir_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_ready;
    logic                  i_operation;
    logic [ADDR_W-1:0]     i_req_size;
    logic [ADDR_W-1:0]     i_address;
    logic                  o_valid;
    logic                  i_ready;
    logic [ADDR_W-1:0]     o_result_address;
    logic [STATUS_W-1:0]   o_status;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [ADDR_W-1:0]     i_cfg_data;

    // Shadow of the allocator: configuration, block table and heap fill.
    logic [ADDR_W-1:0] cfg_base;
    logic [ADDR_W-1:0] cfg_limit;
    logic [HDR_W-1:0]  cfg_hdr;
    logic [ADDR_W-1:0] blk_base [MAX_BLOCKS];
    logic [ADDR_W-1:0] blk_size [MAX_BLOCKS];
    logic              blk_free [MAX_BLOCKS];
    int                blk_count;
    logic [ADDR_W-1:0] used_bytes;

    t_grant pending_grants[$];

    int err_count;
    int items_sent;
    int cfg_writes;
    int status_tally [6];
    int send_idle;
    int recv_stall;

    // Directed stimulus, walked once right after reset with the default
    // configuration (base 0, limit 65536, header 24).
    t_dir_row dir_table [DIR_ROWS] = '{
        // zero size, address field at its top value
        '{OP_ALLOC, 32'd0,          32'hFFFF_FFFF, 1'b1, 32'd0,  ST_IGNORED},
        // null free, size field at its top value
        '{OP_FREE,  32'hFFFF_FFFF,  32'd0,         1'b1, 32'd0,  ST_IGNORED},
        // free on an empty table
        '{OP_FREE,  32'd0,          32'd24,        1'b1, 32'd0,  ST_UNKNOWN},
        '{OP_ALLOC, 32'd100,        32'd0,         1'b1, 32'd24, ST_OK},
        // largest request, must not wrap the space test
        '{OP_ALLOC, 32'hFFFF_FFFF,  32'd0,         1'b1, 32'd0,  ST_HEAP_FULL},
        // one byte past the limit
        '{OP_ALLOC, 32'd65389,      32'd0,         1'b1, 32'd0,  ST_HEAP_FULL},
        // exactly up to the limit
        '{OP_ALLOC, 32'd65388,      32'd0,         1'b0, 32'd0,  ST_OK},
        '{OP_ALLOC, 32'd1,          32'd0,         1'b1, 32'd0,  ST_HEAP_FULL},
        '{OP_FREE,  32'd0,          32'd24,        1'b1, 32'd0,  ST_OK},
        '{OP_FREE,  32'd0,          32'd24,        1'b1, 32'd0,  ST_DOUBLE_FREE},
        // reuse of a larger free block
        '{OP_ALLOC, 32'd50,         32'd0,         1'b0, 32'd0,  ST_OK},
        '{OP_ALLOC, 32'd101,        32'd0,         1'b0, 32'd0,  ST_OK},
        '{OP_FREE,  32'd0,          32'd148,       1'b0, 32'd0,  ST_OK},
        '{OP_ALLOC, 32'd65388,      32'd0,         1'b0, 32'd0,  ST_OK},
        // one byte off a payload address
        '{OP_FREE,  32'd0,          32'd25,        1'b1, 32'd0,  ST_UNKNOWN},
        '{OP_FREE,  32'd0,          32'hFFFF_FFFF, 1'b1, 32'd0,  ST_UNKNOWN},
        '{OP_FREE,  32'd0,          32'd148,       1'b0, 32'd0,  ST_OK},
        '{OP_FREE,  32'd0,          32'd24,        1'b0, 32'd0,  ST_OK},
        // first fit picks the lowest block that fits, here one of exact size
        '{OP_ALLOC, 32'd100,        32'd0,         1'b0, 32'd0,  ST_OK},
        '{OP_ALLOC, 32'd1,          32'd0,         1'b0, 32'd0,  ST_OK},
        '{OP_ALLOC, 32'd1,          32'd0,         1'b0, 32'd0,  ST_OK},
        '{OP_FREE,  32'h5A5A_5A5A,  32'd148,       1'b0, 32'd0,  ST_OK},
        '{OP_ALLOC, 32'd65389,      32'd0,         1'b0, 32'd0,  ST_OK},
        '{OP_ALLOC, 32'd65388,      32'd0,         1'b0, 32'd0,  ST_OK}
    };

    first_fit_heap_allocator DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_operation      (i_operation),
        .i_req_size       (i_req_size),
        .i_address        (i_address),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_result_address (o_result_address),
        .o_status         (o_status),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #25_000_000;
        $display("Timeout: %0d result items still outstanding", pending_grants.size());
        $display("*** FAILED ***");
        $finish;
    end

    task automatic report_mismatch(string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        err_count++;
    endtask

    // Compute the result item of one request and advance the shadow state.
    function automatic t_grant predict_grant(logic op, logic [ADDR_W-1:0] size,
                                             logic [ADDR_W-1:0] addr);
        t_grant            g;
        logic [NEED_W-1:0] need;
        int                k;
        g.addr   = '0;
        g.status = ST_OK;
        if (op == OP_ALLOC) begin
            if (size == '0) begin
                g.status = ST_IGNORED;
                return g;
            end
            for (k = 0; k < blk_count; k++) begin
                if (blk_free[k] && blk_size[k] >= size) begin
                    blk_free[k] = 1'b0;
                    g.addr = blk_base[k] + ADDR_W'(cfg_hdr);
                    return g;
                end
            end
            // Table capacity is tested before heap space.
            if (blk_count >= MAX_BLOCKS) begin
                g.status = ST_TABLE_FULL;
                return g;
            end
            need = NEED_W'(used_bytes) + NEED_W'(cfg_hdr) + NEED_W'(size);
            if (need > NEED_W'(cfg_limit)) begin
                g.status = ST_HEAP_FULL;
                return g;
            end
            blk_base[blk_count] = cfg_base + used_bytes;
            blk_size[blk_count] = size;
            blk_free[blk_count] = 1'b0;
            g.addr     = blk_base[blk_count] + ADDR_W'(cfg_hdr);
            blk_count  = blk_count + 1;
            used_bytes = need[ADDR_W-1:0];
        end else begin
            if (addr == '0) begin
                g.status = ST_IGNORED;
                return g;
            end
            // The lowest matching entry wins when several share an address.
            for (k = 0; k < blk_count; k++) begin
                if (blk_base[k] + ADDR_W'(cfg_hdr) == addr) begin
                    if (blk_free[k]) begin
                        g.status = ST_DOUBLE_FREE;
                    end else begin
                        blk_free[k] = 1'b1;
                    end
                    return g;
                end
            end
            g.status = ST_UNKNOWN;
        end
        return g;
    endfunction

    // Write one register; the block must be idle.
    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        // Drop valid for one cycle so a following write gets a fresh edge.
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        cfg_writes++;
        case (idx)
            CFG_HEAP_BASE: begin
                cfg_base = data;
            end
            CFG_HEAP_LIMIT: begin
                cfg_limit = data;
            end
            CFG_HEADER: begin
                cfg_hdr = data[HDR_W-1:0];
            end
            default: begin
            end
        endcase
    endtask

    // Send one request item, then predict its result once it is accepted.
    task automatic issue(logic op, logic [ADDR_W-1:0] size, logic [ADDR_W-1:0] addr,
                         logic typed, t_grant typed_grant);
        t_grant g;
        while ($urandom_range(0, 99) < send_idle) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_operation <= op;
        i_req_size  <= size;
        i_address   <= addr;
        do @(posedge i_clk); while (!o_ready);
        g = predict_grant(op, size, addr);
        if (typed) begin
            g = typed_grant;
        end
        status_tally[g.status]++;
        pending_grants.push_back(g);
        items_sent++;
    endtask

    // Hold the sender until every expected result item has come back.
    task automatic drain_results();
        i_valid <= 1'b0;
        while (pending_grants.size() != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    // Random traffic: half allocations, half frees, most frees aimed at
    // addresses the table actually holds.
    task automatic run_random(int count, int hold_every);
        int                n;
        int                r;
        int                k;
        logic              op;
        logic [ADDR_W-1:0] size;
        logic [ADDR_W-1:0] addr;
        for (n = 0; n < count; n++) begin
            op   = OP_ALLOC;
            size = $urandom;
            addr = $urandom;
            if ($urandom_range(0, 99) < 50) begin
                r = $urandom_range(0, 99);
                if (r < 3) begin
                    size = '0;
                end else if (r < 8) begin
                    size = $urandom;
                end else if (r < 11) begin
                    // near the top of the range, for the overflow-free space test
                    size = 32'hFFFF_FFFF - $urandom_range(0, 32'h0002_0000);
                end else if (r < 25) begin
                    size = $urandom_range(1, 4096);
                end else begin
                    size = $urandom_range(1, 128);
                end
            end else begin
                op = OP_FREE;
                r  = $urandom_range(0, 99);
                if (r < 5) begin
                    addr = '0;
                end else if (r < 15 || blk_count == 0) begin
                    addr = $urandom;
                end else begin
                    k    = $urandom_range(0, blk_count - 1);
                    addr = blk_base[k] + ADDR_W'(cfg_hdr);
                end
            end
            issue(op, size, addr, 1'b0, '0);
            if (hold_every != 0 && n % hold_every == hold_every - 1) begin
                drain_results();
            end
        end
        drain_results();
    endtask

    // Result side: check each accepted item against the oldest expectation
    // and stall at random.
    initial begin
        t_grant exp_g;
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) begin
                if (pending_grants.size() == 0) begin
                    report_mismatch($sformatf("unexpected item addr=%h status=%0d",
                                              o_result_address, o_status));
                end else begin
                    exp_g = pending_grants.pop_front();
                    if (o_result_address !== exp_g.addr) begin
                        report_mismatch($sformatf("address %h, expected %h",
                                                  o_result_address, exp_g.addr));
                    end
                    if (o_status !== exp_g.status) begin
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  o_status, exp_g.status));
                    end
                end
            end
            i_ready <= ($urandom_range(0, 99) >= recv_stall);
        end
    end

    // Main sequence: reset, directed table, then phases of random traffic,
    // each under its own configuration and idling pattern.
    initial begin
        int     row;
        t_grant typed_g;
        err_count   = 0;
        items_sent  = 0;
        cfg_writes  = 0;
        send_idle   = 0;
        recv_stall  = 0;
        cfg_base    = '0;
        cfg_limit   = 32'd65536;
        cfg_hdr     = 7'd24;
        blk_count   = 0;
        used_bytes  = '0;
        for (row = 0; row < 6; row++) begin
            status_tally[row] = 0;
        end
        for (row = 0; row < MAX_BLOCKS; row++) begin
            blk_free[row] = 1'b0;
        end
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_operation <= OP_ALLOC;
        i_req_size  <= '0;
        i_address   <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_HEAP_BASE;
        i_cfg_data  <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (row = 0; row < DIR_ROWS; row++) begin
            typed_g.addr   = dir_table[row].exp_addr;
            typed_g.status = dir_table[row].exp_status;
            issue(dir_table[row].op, dir_table[row].size, dir_table[row].addr,
                  dir_table[row].typed, typed_g);
        end
        drain_results();

        // Tight heap growth, header of one byte, no idling.
        cfg_write(CFG_HEAP_BASE, 32'h1000_0000);
        cfg_write(CFG_HEAP_LIMIT, used_bytes + 32'd1500);
        cfg_write(CFG_HEADER, 32'd1);
        run_random(150, 0);

        // Move the base so the next new block lands on block 0's base: the
        // table then holds two entries with one payload address.
        cfg_write(CFG_HEAP_BASE, blk_base[0] - used_bytes);
        cfg_write(CFG_HEAP_LIMIT, 32'hFFFF_FFFF);
        cfg_write(CFG_HEADER, 32'd24);
        send_idle = 67;
        issue(OP_ALLOC, 32'h0001_0000, $urandom, 1'b0, '0);
        issue(OP_FREE, $urandom, blk_base[0] + ADDR_W'(cfg_hdr), 1'b0, '0);
        run_random(200, 0);

        // No header, zero limit, top base; receiver stalls.
        cfg_write(CFG_HEAP_BASE, 32'hFFFF_FFFF);
        cfg_write(CFG_HEAP_LIMIT, 32'd0);
        cfg_write(CFG_HEADER, 32'd0);
        send_idle  = 0;
        recv_stall = 67;
        run_random(200, 0);

        // Header above the usual range, written with all data bits set.
        cfg_write(CFG_HEAP_BASE, 32'd0);
        cfg_write(CFG_HEAP_LIMIT, used_bytes + 32'd20000);
        cfg_write(CFG_HEADER, 32'hFFFF_FFFF);
        send_idle  = 37;
        recv_stall = 37;
        run_random(200, 0);

        // Write to the unused index must leave the registers alone.
        cfg_write(CFG_HEAP_BASE, 32'h8000_0000);
        cfg_write(CFG_HEAP_LIMIT, 32'd65536);
        cfg_write(CFG_HEADER, 32'd64);
        cfg_write(CFG_UNUSED, $urandom);
        send_idle  = 20;
        recv_stall = 20;
        run_random(250, 50);

        // Let any stray item show up before the verdict.
        repeat (2 * MAX_BLOCKS + 10) @(posedge i_clk);

        $display("Sent %0d request items under %0d register writes; table holds %0d blocks",
                 items_sent, cfg_writes, blk_count);
        $display("Outcomes: ok %0d, ignored %0d, heap full %0d, table full %0d, %s %0d, %s %0d",
                 status_tally[ST_OK], status_tally[ST_IGNORED], status_tally[ST_HEAP_FULL],
                 status_tally[ST_TABLE_FULL], "unknown", status_tally[ST_UNKNOWN],
                 "double free", status_tally[ST_DOUBLE_FREE]);
        if (err_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches", err_count);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
